FILE: rtl/core/deq_pkg.sv
// Shared types and codes of the double-ended queue unit.
package deq_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StatW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted request
    logic exec;  // update pointers, access the store, latch the result
  } dp_cmd_t;

endpackage

FILE: rtl/core/deq_if.sv
// Handshake interfaces for the request and response channels.
interface deq_req_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::CmdW-1:0]      cmd;
  logic signed [deq_pkg::WordW-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface deq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic signed [deq_pkg::WordW-1:0] pop_value;
  logic [deq_pkg::StatW-1:0]     status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

FILE: rtl/core/deq_ctrl.sv
// Sequencer of the double-ended queue: accept, execute, respond.
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::dp_cmd_t  dp_cmd_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_RESP;
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_RESP);
  assign dp_cmd_o.load = (state_q == S_IDLE) && in_valid_i;
  assign dp_cmd_o.exec = (state_q == S_EXEC);

endmodule

FILE: rtl/core/deq_dp.sv
// Datapath: ring store, head and tail pointers, fill count and result register.
module deq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  deq_pkg::dp_cmd_t               dp_cmd_i,
  input  logic [deq_pkg::CmdW-1:0]       cmd_i,
  input  logic signed [deq_pkg::WordW-1:0] push_value_i,
  output logic signed [deq_pkg::WordW-1:0] pop_value_o,
  output logic [deq_pkg::StatW-1:0]      status_o
);
  import deq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WordW-1:0] mem_q [DEPTH];

  cmd_e                    cmd_q;
  logic signed [WordW-1:0] val_q;
  logic [IdxW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  status_e                 status_q, status_d;
  logic                    pop_ok_q, pop_ok_d;
  logic [WordW-1:0]        rd_data_q;

  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic [IdxW-1:0] head_inc, head_dec, tail_inc, tail_dec;

  assign head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign tail_inc = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? LastIdx : tail_q - 1'b1;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    status_d = ST_DONE;
    pop_ok_d = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = tail_q;
    rd_addr  = head_q;
    case (cmd_q)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (cnt_q == FullCnt) begin
          status_d = ST_FULL;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cmd_q == CMD_PUSH_FRONT) begin
            head_d  = head_dec;
            wr_addr = head_dec;
          end else begin
            tail_d = tail_inc;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          pop_ok_d = 1'b1;
          cnt_d    = cnt_q - 1'b1;
          if (cmd_q == CMD_POP_FRONT) begin
            head_d = head_inc;
          end else begin
            tail_d  = tail_dec;
            rd_addr = tail_dec;
          end
          // Removing the last word brings both ends back to the origin.
          if (cnt_q == CntW'(1)) begin
            head_d = '0;
            tail_d = '0;
          end
        end
      end
      default: status_d = ST_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      status_q <= ST_DONE;
      pop_ok_q <= 1'b0;
    end else if (dp_cmd_i.exec) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      cmd_q <= cmd_e'(cmd_i);
      val_q <= push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.exec && wr_en) begin
      mem_q[wr_addr] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.exec && rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign pop_value_o = pop_ok_q ? $signed(rd_data_q) : '0;
  assign status_o    = status_q;

endmodule

FILE: rtl/core/double_ended_queue_unit.sv
// Top level of the double-ended queue unit.
//   Channel  Dir  Handshake      Payload
//   req_i    in   valid/ready    cmd[1:0], push_value[31:0] signed
//   rsp_o    out  valid/ready    pop_value[31:0] signed, status[1:0]
// Each transaction runs through accept, execute (pointer update and
// store write or registered store read), then the response is held.
// One transaction is in flight at a time; a new request is taken the cycle
// after the response transaction completes. A stalled response holds.
// Reset clears the pointers and fill count at once; the store needs no clearing.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  deq_req_if.sink  req_i,
  deq_rsp_if.source rsp_o
);
  import deq_pkg::*;

  dp_cmd_t dp_cmd;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .dp_cmd_o    (dp_cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dp_cmd_i     (dp_cmd),
    .cmd_i        (req_i.cmd),
    .push_value_i (req_i.push_value),
    .pop_value_o  (rsp_o.pop_value),
    .status_o     (rsp_o.status)
  );

endmodule

FILE: rtl/core/deq_checker.sv
// Port-level checks of the double-ended queue unit and their binding.
module deq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic signed [deq_pkg::WordW-1:0] rsp_pop_value_i,
  input logic [deq_pkg::StatW-1:0]      rsp_status_i
);
  import deq_pkg::*;

  // A refused push or pop never carries a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_FULL || rsp_status_i == ST_EMPTY)
      |-> rsp_pop_value_i == '0)
    else $error("refused transaction carries a nonzero word");

  // Only one transaction is in flight: no request is taken while a response waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("request ready while a response is pending");

  // A response appears after its request transaction, once the execute state has passed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> ##1 rsp_valid_i)
    else $error("response missing two cycles after request");

  // After a response transaction the unit is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ready_i |=> req_ready_i && !rsp_valid_i)
    else $error("unit not idle after response transaction");

  // Status never takes the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == ST_DONE || rsp_status_i == ST_EMPTY ||
                     rsp_status_i == ST_FULL))
    else $error("response status out of range");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_pop_value_i (rsp_o.pop_value),
  .rsp_status_i    (rsp_o.status)
);
